// File: src/brts_pkg.sv
// Shared types, constants and register map for the bilinear RGB tile sampler.
// No dependencies; used by every module under src.
package brts_pkg;

  localparam int unsigned COORD_W     = 12;
  localparam int unsigned PIX_W       = 24;
  localparam int unsigned CH_W        = 8;
  localparam int unsigned NUM_CH      = 3;
  localparam int unsigned ACC_W       = 16;
  localparam int unsigned WGT_W       = 9;
  localparam int unsigned FRAC_W      = 5;
  localparam int unsigned FRAC_ONE    = 16;
  localparam int unsigned ROUND_BIAS  = 128;
  localparam int unsigned NUM_TAPS    = 4;
  localparam int unsigned TAP_W       = 2;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned TILE_W_DEF  = 256;
  localparam int unsigned TILE_H_DEF  = 256;
  localparam int unsigned PADDR_W     = 5;
  localparam int unsigned PDATA_W     = 32;
  localparam int unsigned SUB_MAX_RST = 256;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_SAMPLE,
    CMD_COVERED
  } cmd_e;

  typedef enum logic [2:0] {
    REG_FRAC_X     = 3'd0,
    REG_FRAC_Y     = 3'd1,
    REG_BASE_X     = 3'd2,
    REG_BASE_Y     = 3'd3,
    REG_SUB_LEFT   = 3'd4,
    REG_SUB_RIGHT  = 3'd5,
    REG_SUB_TOP    = 3'd6,
    REG_SUB_BOTTOM = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic               operation;
    logic [11:0]        col;
    logic [11:0]        row;
    logic [PIX_W-1:0]   load_pixel;
    logic               covered;
  } in_item_t;

  typedef struct packed {
    logic               write_enable;
    logic [PIX_W-1:0]   out_pixel;
  } out_item_t;

  typedef struct packed {
    logic [4:0]         frac_x;
    logic [4:0]         frac_y;
    logic signed [13:0] base_x;
    logic signed [13:0] base_y;
    logic [7:0]         sub_left;
    logic [8:0]         sub_right;
    logic [7:0]         sub_top;
    logic [8:0]         sub_bottom;
  } cfg_t;

  typedef struct packed {
    cmd_e               kind;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] y1;
    logic [PIX_W-1:0]   pixel;
  } cmd_t;

endpackage

// File: src/bilinear_rgb_tile_sampler.sv
// Bilinear RGB888 tile sampler: configuration registers and the front/queue/back split.
// Depends on brts_pkg, brts_front, brts_queue and brts_back.
//
// Load beats write one pixel of the source tile; a covered sample reads no tile memory;
// an uncovered sample makes one read of the single-port tile memory per tap, and the
// back end takes no new command before its last tap read. That read is registered, then
// the result in the output beat. The tile memory is never cleared: samples must only
// touch pixels that have been loaded. Input and output stall independently through a
// four-entry command queue and a registered output beat.
module bilinear_rgb_tile_sampler #(
  parameter int unsigned TILE_W = brts_pkg::TILE_W_DEF,
  parameter int unsigned TILE_H = brts_pkg::TILE_H_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  brts_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output brts_pkg::out_item_t           out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [brts_pkg::PADDR_W-1:0]  paddr,
  input  logic [brts_pkg::PDATA_W-1:0]  pwdata,
  output logic [brts_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam brts_pkg::cfg_t CfgRst = '{
    frac_x:     '0,
    frac_y:     '0,
    base_x:     '0,
    base_y:     '0,
    sub_left:   '0,
    sub_right:  9'(brts_pkg::SUB_MAX_RST),
    sub_top:    '0,
    sub_bottom: 9'(brts_pkg::SUB_MAX_RST)
  };

  brts_pkg::cfg_t     cfg_q, cfg_d;
  brts_pkg::reg_idx_e reg_idx;
  logic               cfg_wr;
  logic               q_push, q_full, q_pop, q_valid;
  brts_pkg::cmd_t     q_cmd, q_head;

  assign pready  = 1'b1;
  assign reg_idx = brts_pkg::reg_idx_e'(paddr[brts_pkg::PADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (reg_idx)
        brts_pkg::REG_FRAC_X:     cfg_d.frac_x     = pwdata[4:0];
        brts_pkg::REG_FRAC_Y:     cfg_d.frac_y     = pwdata[4:0];
        brts_pkg::REG_BASE_X:     cfg_d.base_x     = $signed(pwdata[13:0]);
        brts_pkg::REG_BASE_Y:     cfg_d.base_y     = $signed(pwdata[13:0]);
        brts_pkg::REG_SUB_LEFT:   cfg_d.sub_left   = pwdata[7:0];
        brts_pkg::REG_SUB_RIGHT:  cfg_d.sub_right  = pwdata[8:0];
        brts_pkg::REG_SUB_TOP:    cfg_d.sub_top    = pwdata[7:0];
        brts_pkg::REG_SUB_BOTTOM: cfg_d.sub_bottom = pwdata[8:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      brts_pkg::REG_FRAC_X:     prdata = brts_pkg::PDATA_W'(cfg_q.frac_x);
      brts_pkg::REG_FRAC_Y:     prdata = brts_pkg::PDATA_W'(cfg_q.frac_y);
      brts_pkg::REG_BASE_X:     prdata = brts_pkg::PDATA_W'($unsigned(cfg_q.base_x));
      brts_pkg::REG_BASE_Y:     prdata = brts_pkg::PDATA_W'($unsigned(cfg_q.base_y));
      brts_pkg::REG_SUB_LEFT:   prdata = brts_pkg::PDATA_W'(cfg_q.sub_left);
      brts_pkg::REG_SUB_RIGHT:  prdata = brts_pkg::PDATA_W'(cfg_q.sub_right);
      brts_pkg::REG_SUB_TOP:    prdata = brts_pkg::PDATA_W'(cfg_q.sub_top);
      brts_pkg::REG_SUB_BOTTOM: prdata = brts_pkg::PDATA_W'(cfg_q.sub_bottom);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  brts_front #(
    .TILE_W(TILE_W),
    .TILE_H(TILE_H)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i (in_data_i),
    .cfg_i     (cfg_q),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_cmd_o   (q_cmd)
  );

  brts_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(q_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  brts_back #(
    .TILE_W(TILE_W),
    .TILE_H(TILE_H)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_valid_i  (q_valid),
    .q_head_i   (q_head),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

// File: src/brts_front.sv
// Front end: accepts input beats, drops loads outside the tile, clamps sample taps.
// Depends on brts_pkg.
module brts_front #(
  parameter int unsigned TILE_W = brts_pkg::TILE_W_DEF,
  parameter int unsigned TILE_H = brts_pkg::TILE_H_DEF
) (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  brts_pkg::in_item_t in_data_i,
  input  brts_pkg::cfg_t    cfg_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output brts_pkg::cmd_t    q_cmd_o
);

  function automatic logic [brts_pkg::COORD_W-1:0] clamp_tap(
    input logic signed [15:0] v,
    input logic signed [15:0] lo,
    input logic signed [15:0] hi,
    input logic signed [15:0] top
  );
    logic signed [15:0] r;
    r = v;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    if (r < 16'sd0) r = 16'sd0;
    if (r > top) r = top;
    return r[brts_pkg::COORD_W-1:0];
  endfunction

  localparam logic signed [15:0] XTop = 16'(TILE_W - 1);
  localparam logic signed [15:0] YTop = 16'(TILE_H - 1);

  logic signed [15:0] ix, iy, ix1, iy1;
  logic signed [15:0] xlo, xhi, ylo, yhi;
  logic               in_tile;

  assign in_ready_o = !q_full_i;

  always_comb begin
    ix  = $signed({4'b0, in_data_i.col}) + 16'(cfg_i.base_x);
    iy  = $signed({4'b0, in_data_i.row}) + 16'(cfg_i.base_y);
    ix1 = ix + 16'sd1;
    iy1 = iy + 16'sd1;
    xlo = $signed({8'b0, cfg_i.sub_left});
    ylo = $signed({8'b0, cfg_i.sub_top});
    xhi = $signed({7'b0, cfg_i.sub_right}) - 16'sd1;
    yhi = $signed({7'b0, cfg_i.sub_bottom}) - 16'sd1;
    in_tile = ({4'b0, in_data_i.col} < 16'(TILE_W)) && ({4'b0, in_data_i.row} < 16'(TILE_H));

    q_cmd_o.pixel = in_data_i.load_pixel;
    if (in_data_i.operation == brts_pkg::OP_LOAD) begin
      q_cmd_o.kind = brts_pkg::CMD_LOAD;
      q_cmd_o.x0   = in_data_i.col;
      q_cmd_o.x1   = in_data_i.col;
      q_cmd_o.y0   = in_data_i.row;
      q_cmd_o.y1   = in_data_i.row;
    end else begin
      q_cmd_o.kind = in_data_i.covered ? brts_pkg::CMD_COVERED : brts_pkg::CMD_SAMPLE;
      q_cmd_o.x0   = clamp_tap(ix, xlo, xhi, XTop);
      q_cmd_o.x1   = clamp_tap(ix1, xlo, xhi, XTop);
      q_cmd_o.y0   = clamp_tap(iy, ylo, yhi, YTop);
      q_cmd_o.y1   = clamp_tap(iy1, ylo, yhi, YTop);
    end

    q_push_o = in_valid_i && in_ready_o
               && ((in_data_i.operation == brts_pkg::OP_SAMPLE) || in_tile);
  end

endmodule

// File: src/brts_queue.sv
// Command queue between front and back ends, four entries deep.
// Depends on brts_pkg.
module brts_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  brts_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output brts_pkg::cmd_t head_o
);

  localparam int unsigned Depth = brts_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  brts_pkg::cmd_t  entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count lost a push");

endmodule

// File: src/brts_back.sv
// Back end: tile memory, four-tap read sequencer, weighted accumulate, output register.
// Depends on brts_pkg.
module brts_back #(
  parameter int unsigned TILE_W = brts_pkg::TILE_W_DEF,
  parameter int unsigned TILE_H = brts_pkg::TILE_H_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  brts_pkg::cfg_t      cfg_i,
  input  logic                q_valid_i,
  input  brts_pkg::cmd_t      q_head_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output brts_pkg::out_item_t out_data_o
);

  localparam int unsigned Depth = TILE_W * TILE_H;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam logic [brts_pkg::TAP_W-1:0] TapLast = brts_pkg::TAP_W'(brts_pkg::NUM_TAPS - 1);

  typedef struct packed {
    logic [brts_pkg::TAP_W-1:0] tap;
    logic                       last;
    logic                       cov;
  } rd_info_t;

  logic [brts_pkg::PIX_W-1:0] tile_mem_q [Depth];
  logic [brts_pkg::PIX_W-1:0] rd_data_q;
  logic [brts_pkg::WGT_W-1:0] wgt_q [brts_pkg::NUM_TAPS];
  logic [brts_pkg::WGT_W-1:0] wgt_d [brts_pkg::NUM_TAPS];
  logic [brts_pkg::ACC_W-1:0] acc_q [brts_pkg::NUM_CH];
  logic [brts_pkg::ACC_W-1:0] acc_d [brts_pkg::NUM_CH];
  logic [brts_pkg::TAP_W-1:0] tap_cnt_q, tap_cnt_d;
  logic                       rd_vld_q, rd_vld_d;
  rd_info_t                   rd_info_q, rd_info_d;
  logic                       out_vld_q, out_vld_d;
  brts_pkg::out_item_t        out_q, out_d;

  logic [brts_pkg::FRAC_W-1:0] fx, fy, fxn, fyn;
  logic [brts_pkg::COORD_W-1:0] cx, cy;
  logic [AddrW-1:0]            addr;
  logic                        stall, issue, do_load, do_read, finish;
  logic [brts_pkg::ACC_W:0]    sum [brts_pkg::NUM_CH];

  always_comb begin
    fx  = (cfg_i.frac_x > brts_pkg::FRAC_W'(brts_pkg::FRAC_ONE))
          ? brts_pkg::FRAC_W'(brts_pkg::FRAC_ONE) : cfg_i.frac_x;
    fy  = (cfg_i.frac_y > brts_pkg::FRAC_W'(brts_pkg::FRAC_ONE))
          ? brts_pkg::FRAC_W'(brts_pkg::FRAC_ONE) : cfg_i.frac_y;
    fxn = brts_pkg::FRAC_W'(brts_pkg::FRAC_ONE) - fx;
    fyn = brts_pkg::FRAC_W'(brts_pkg::FRAC_ONE) - fy;
    wgt_d[0] = brts_pkg::WGT_W'({5'b0, fxn} * {5'b0, fyn});
    wgt_d[1] = brts_pkg::WGT_W'({5'b0, fx}  * {5'b0, fyn});
    wgt_d[2] = brts_pkg::WGT_W'({5'b0, fxn} * {5'b0, fy});
    wgt_d[3] = brts_pkg::WGT_W'({5'b0, fx}  * {5'b0, fy});
  end

  // tap order: top-left, top-right, bottom-left, bottom-right
  always_comb begin
    stall   = rd_vld_q && rd_info_q.last && out_vld_q && !out_ready_i;
    issue   = q_valid_i && !stall;
    do_load = issue && (q_head_i.kind == brts_pkg::CMD_LOAD);
    do_read = issue && (q_head_i.kind == brts_pkg::CMD_SAMPLE);
    q_pop_o = issue && ((q_head_i.kind != brts_pkg::CMD_SAMPLE) || (tap_cnt_q == TapLast));
    cx      = tap_cnt_q[0] ? q_head_i.x1 : q_head_i.x0;
    cy      = tap_cnt_q[1] ? q_head_i.y1 : q_head_i.y0;
    addr    = AddrW'(AddrW'(cy) * AddrW'(TILE_W) + AddrW'(cx));

    tap_cnt_d = do_read ? tap_cnt_q + 1'b1 : tap_cnt_q;

    rd_vld_d  = rd_vld_q;
    rd_info_d = rd_info_q;
    if (!stall) begin
      rd_vld_d       = issue && (q_head_i.kind != brts_pkg::CMD_LOAD);
      rd_info_d.tap  = tap_cnt_q;
      rd_info_d.cov  = (q_head_i.kind == brts_pkg::CMD_COVERED);
      rd_info_d.last = (q_head_i.kind == brts_pkg::CMD_COVERED) || (tap_cnt_q == TapLast);
    end
  end

  always_comb begin
    finish = rd_vld_q && rd_info_q.last && !stall;
    out_d  = out_q;
    for (int c = 0; c < brts_pkg::NUM_CH; c++) begin
      sum[c] = ((rd_info_q.tap == '0) ? (brts_pkg::ACC_W + 1)'(brts_pkg::ROUND_BIAS)
                                      : {1'b0, acc_q[c]})
               + (brts_pkg::ACC_W + 1)'(rd_data_q[c*brts_pkg::CH_W +: brts_pkg::CH_W]
                                        * wgt_q[rd_info_q.tap]);
      acc_d[c] = sum[c][brts_pkg::ACC_W-1:0];
      out_d.out_pixel[c*brts_pkg::CH_W +: brts_pkg::CH_W] =
        rd_info_q.cov ? '0 : sum[c][brts_pkg::ACC_W-1:brts_pkg::CH_W];
    end
    out_d.write_enable = !rd_info_q.cov;
    if (!finish) begin
      out_d = out_q;
    end
    out_vld_d = finish || (out_vld_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_cnt_q <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      tap_cnt_q <= tap_cnt_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_load) begin
      tile_mem_q[addr] <= q_head_i.pixel;
    end
    if (do_read) begin
      rd_data_q <= tile_mem_q[addr];
    end
    rd_info_q <= rd_info_d;
    out_q     <= out_d;
    wgt_q     <= wgt_d;
    if (rd_vld_q && !rd_info_q.last) begin
      acc_q <= acc_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (tap_cnt_q != '0) |-> (q_valid_i && (q_head_i.kind == brts_pkg::CMD_SAMPLE)))
    else $error("tap sequence lost its sample command");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (rd_vld_q && rd_info_q.last && !rd_info_q.cov) |-> (rd_info_q.tap == TapLast))
    else $error("sample finished before its last tap");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $rose(out_vld_q) |-> $past(rd_vld_q && rd_info_q.last))
    else $error("result appeared without a finishing beat");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_vld_q && !out_q.write_enable) |-> (out_q.out_pixel == '0))
    else $error("covered result carries pixel data");

endmodule
